// ===== rtl/core/ubx_position_frame_parser_macros.svh =====
// Assertion helpers for the frame parser.
`ifndef UBX_POSITION_FRAME_PARSER_MACROS_SVH
`define UBX_POSITION_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UBX_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UBX_ASSERT(lbl, prop, msg) `UBX_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define UBX_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define UBX_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/ubx_pfp_pkg.sv =====
`default_nettype none

package ubx_pfp_pkg;

    localparam int MAX_PAYLOAD = 120;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] NAV_CLASS   = 8'h01;
    localparam logic [7:0] PVT_ID      = 8'h07;

    localparam int LAT_OFFSET = 28;
    localparam int LON_OFFSET = 24;

    localparam int IN_W  = 8;
    localparam int OUT_W = 29;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit unsigned x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

endpackage

`default_nettype wire

// ===== rtl/core/ubx_position_frame_parser.sv =====
// Parses a byte stream of binary navigation frames (sync 0xB5 0x62, class, id,
// little-endian length, payload, two unchecked checksum bytes) and, after each
// frame of class 0x01 id 0x07, emits one beat carrying the latitude word
// (payload bytes 28..31) and longitude word (bytes 24..27), each signed and
// divided by ten with truncation toward zero. Frames longer than MAX_PAYLOAD
// are dropped at the length field. One byte is taken per cycle while the input
// is not stalled; the result beat passes through a capture stage (sign and
// magnitude) and a reciprocal-multiply stage that feeds the output register.
// Back-pressure on the output stalls the input only when both stages hold
// results.
`default_nettype none

`include "ubx_position_frame_parser_macros.svh"

module ubx_position_frame_parser (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [ubx_pfp_pkg::IN_W-1:0]        i_s_tdata,   // [7:0] rx_byte
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [ubx_pfp_pkg::OUT_TDATA_W-1:0]      o_m_tdata    // [28:0] latitude_value,
                                                                  // [57:29] longitude_value
);

    localparam int LW = ubx_pfp_pkg::LEN_W;
    localparam int OW = ubx_pfp_pkg::OUT_W;

    typedef enum logic [3:0] {
        ST_HUNT  = 4'd0,
        ST_SYNC2 = 4'd1,
        ST_CLASS = 4'd2,
        ST_ID    = 4'd3,
        ST_LENLO = 4'd4,
        ST_LENHI = 4'd5,
        ST_PAYLD = 4'd6,
        ST_CK1   = 4'd7,
        ST_CK2   = 4'd8
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [7:0]     r_class, n_class;
    logic [7:0]     r_id, n_id;
    logic [7:0]     r_len_lo, n_len_lo;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_index, n_index;
    logic [31:0]    r_lat, n_lat;
    logic [31:0]    r_lon, n_lon;

    logic           r_s1_valid;
    logic [31:0]    r_s1_lat_abs, r_s1_lon_abs;
    logic           r_s1_lat_neg, r_s1_lon_neg;

    logic           r_out_valid;
    logic [OW-1:0]  r_out_lat, r_out_lon;

    logic           out_ready, s1_ready, s_fire, emit;
    logic [15:0]    full_len;
    logic [LW:0]    idx_inc;
    logic [63:0]    lat_prod, lon_prod;
    logic [OW-1:0]  lat_q, lon_q, lat_res, lon_res;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_s_tready = s1_ready;
    assign s_fire     = i_s_tvalid && s1_ready;

    assign full_len = {i_s_tdata, r_len_lo};
    assign idx_inc  = {1'b0, r_index} + (LW+1)'(1);

    always_comb begin
        n_phase  = r_phase;
        n_class  = r_class;
        n_id     = r_id;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_index  = r_index;
        n_lat    = r_lat;
        n_lon    = r_lon;
        emit     = 1'b0;
        unique case (r_phase)
            ST_SYNC2: n_phase = (i_s_tdata == ubx_pfp_pkg::SYNC_SECOND) ? ST_CLASS : ST_HUNT;
            ST_CLASS: begin
                n_class = i_s_tdata;
                n_phase = ST_ID;
            end
            ST_ID: begin
                n_id    = i_s_tdata;
                n_phase = ST_LENLO;
            end
            ST_LENLO: begin
                n_len_lo = i_s_tdata;
                n_phase  = ST_LENHI;
            end
            ST_LENHI: begin
                n_len   = LW'(full_len);
                n_index = '0;
                if (full_len > 16'(ubx_pfp_pkg::MAX_PAYLOAD)) begin
                    n_phase = ST_HUNT;
                end else if (full_len == 16'd0) begin
                    n_phase = ST_CK1;
                end else begin
                    n_phase = ST_PAYLD;
                end
            end
            ST_PAYLD: begin
                // offsets are word aligned, so the low index bits pick the byte lane
                if (r_index >= LW'(ubx_pfp_pkg::LAT_OFFSET) &&
                    r_index <  LW'(ubx_pfp_pkg::LAT_OFFSET + 4)) begin
                    n_lat[8*r_index[1:0] +: 8] = i_s_tdata;
                end else if (r_index >= LW'(ubx_pfp_pkg::LON_OFFSET) &&
                             r_index <  LW'(ubx_pfp_pkg::LON_OFFSET + 4)) begin
                    n_lon[8*r_index[1:0] +: 8] = i_s_tdata;
                end
                n_index = LW'(idx_inc);
                if (idx_inc >= {1'b0, r_len}) begin
                    n_phase = ST_CK1;
                end
            end
            ST_CK1: n_phase = ST_CK2;
            ST_CK2: begin
                emit    = (r_class == ubx_pfp_pkg::NAV_CLASS) && (r_id == ubx_pfp_pkg::PVT_ID);
                n_phase = ST_HUNT;
            end
            default: n_phase = (i_s_tdata == ubx_pfp_pkg::SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
        endcase
    end

    assign lat_prod = 64'(r_s1_lat_abs) * 64'(ubx_pfp_pkg::RECIP_10);
    assign lon_prod = 64'(r_s1_lon_abs) * 64'(ubx_pfp_pkg::RECIP_10);
    assign lat_q    = lat_prod[ubx_pfp_pkg::RECIP_SHIFT +: OW];
    assign lon_q    = lon_prod[ubx_pfp_pkg::RECIP_SHIFT +: OW];
    assign lat_res  = r_s1_lat_neg ? (~lat_q + OW'(1)) : lat_q;
    assign lon_res  = r_s1_lon_neg ? (~lon_q + OW'(1)) : lon_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_HUNT;
            r_class     <= '0;
            r_id        <= '0;
            r_len_lo    <= '0;
            r_len       <= '0;
            r_index     <= '0;
            r_lat       <= '0;
            r_lon       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase  <= n_phase;
                r_class  <= n_class;
                r_id     <= n_id;
                r_len_lo <= n_len_lo;
                r_len    <= n_len;
                r_index  <= n_index;
                r_lat    <= n_lat;
                r_lon    <= n_lon;
            end
            if (s1_ready) begin
                r_s1_valid <= s_fire && emit;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (s1_ready && s_fire && emit) begin
            r_s1_lat_neg <= r_lat[31];
            r_s1_lon_neg <= r_lon[31];
            r_s1_lat_abs <= r_lat[31] ? (~r_lat + 32'd1) : r_lat;
            r_s1_lon_abs <= r_lon[31] ? (~r_lon + 32'd1) : r_lon;
        end
        if (out_ready && r_s1_valid) begin
            r_out_lat <= lat_res;
            r_out_lon <= lon_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(ubx_pfp_pkg::OUT_TDATA_W - 2*OW)'(0), r_out_lon, r_out_lat};

    `UBX_ASSERT(a_payload_bounds,
        (r_phase == ST_PAYLD) |->
            (r_index < r_len && r_len <= LW'(ubx_pfp_pkg::MAX_PAYLOAD)),
        "payload index or length out of range")
    `UBX_ASSERT(a_s1_holds, (r_s1_valid && !out_ready) |=> r_s1_valid,
        "capture stage lost a result under stall")
    `UBX_ASSERT(a_s1_source, $rose(r_s1_valid) |-> $past(s_fire && r_phase == ST_CK2),
        "result captured outside frame end")

endmodule

`default_nettype wire
